>>> rtl/core/ble_pkg.sv
// Shared types and constants for the bounded list engine.
// Used by ble_ctrl and bounded_list_engine_core; depends on nothing else.
package ble_pkg;

    localparam int VAL_W  = 32;
    localparam int POS_W  = 8;
    localparam int LEN_W  = 7;
    localparam int KIND_W = 3;
    localparam int GRP_W  = 2;
    localparam int ST_W   = 2;

    typedef enum logic [KIND_W-1:0] {
        KIND_PUSH_FRONT  = 3'd0,
        KIND_PUSH_BACK   = 3'd1,
        KIND_INSERT      = 3'd2,
        KIND_READ        = 3'd3,
        KIND_SPLIT_PAR   = 3'd4,
        KIND_SPLIT_AT    = 3'd5
    } kind_t;

    localparam logic [ST_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [ST_W-1:0] STATUS_BAD   = 2'd1;
    localparam logic [ST_W-1:0] STATUS_FULL  = 2'd2;
    localparam logic [ST_W-1:0] STATUS_EMPTY = 2'd3;

    localparam logic [GRP_W-1:0] GROUP_FIRST  = 2'd0;
    localparam logic [GRP_W-1:0] GROUP_SECOND = 2'd1;
    localparam logic [GRP_W-1:0] GROUP_SINGLE = 2'd2;

    typedef struct packed {
        logic signed [VAL_W-1:0] item_value;
        logic [GRP_W-1:0]        group;
        logic [ST_W-1:0]         status;
        logic                    last;
        logic [LEN_W-1:0]        length;
    } result_t;

endpackage

>>> rtl/core/ble_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Stands alone; no package dependency.
module ble_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

>>> rtl/core/ble_ctrl.sv
// Sequencer that runs every list operation over the element RAM, one step a cycle while results are taken.
// Depends on ble_pkg and instantiates ble_ram.
module ble_ctrl #(
    parameter int CAPACITY = 64
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   req_valid,
    output logic                   req_ready,
    input  logic [2:0]             kind,
    input  logic [7:0]             position,
    input  logic signed [31:0]     value,
    output logic                   res_valid,
    input  logic                   res_ready,
    output ble_pkg::result_t       res
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int LW = ble_pkg::LEN_W;
    localparam int PW = ble_pkg::POS_W;
    localparam int VW = ble_pkg::VAL_W;

    typedef enum logic [7:0] {
        S_IDLE     = 8'b0000_0001,
        S_SHIFT_RD = 8'b0000_0010,
        S_SHIFT    = 8'b0000_0100,
        S_WRITE    = 8'b0000_1000,
        S_RD_WAIT  = 8'b0001_0000,
        S_REPLY    = 8'b0010_0000,
        S_STRM_RD  = 8'b0100_0000,
        S_STRM     = 8'b1000_0000
    } state_t;

    state_t                    state_reg, state_next;
    logic [LW-1:0]             len_reg, len_next;
    logic [AW-1:0]             dst_reg, dst_next;
    logic [AW-1:0]             ins_reg, ins_next;
    logic [AW-1:0]             idx_reg, idx_next;
    logic [LW-1:0]             cnt_reg, cnt_next;
    logic                      pass_reg, pass_next;
    logic                      parity_reg, parity_next;
    logic [PW-1:0]             pos_reg, pos_next;
    logic [VW-1:0]             val_reg, val_next;
    logic [ble_pkg::ST_W-1:0]  rep_st_reg, rep_st_next;

    logic          ram_we;
    logic [AW-1:0] ram_waddr;
    logic [VW-1:0] ram_wdata;
    logic          ram_re;
    logic [AW-1:0] ram_raddr;
    logic [VW-1:0] ram_rdata;

    logic full;
    logic pos_bad;
    logic want;
    logic advance;
    logic more;

    ble_ram #(
        .WIDTH(VW),
        .DEPTH(CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign full    = (len_reg >= LW'(CAPACITY));
    assign pos_bad = (position == '0) || (position > PW'(len_reg));
    assign want    = parity_reg ? (ram_rdata[0] == pass_reg) : 1'b1;
    assign more    = ((LW'(idx_reg) + LW'(1)) < len_reg);

    always_comb
    begin
        state_next  = state_reg;
        len_next    = len_reg;
        dst_next    = dst_reg;
        ins_next    = ins_reg;
        idx_next    = idx_reg;
        cnt_next    = cnt_reg;
        pass_next   = pass_reg;
        parity_next = parity_reg;
        pos_next    = pos_reg;
        val_next    = val_reg;
        rep_st_next = rep_st_reg;
        ram_we      = 1'b0;
        ram_waddr   = ins_reg;
        ram_wdata   = val_reg;
        ram_re      = 1'b0;
        ram_raddr   = '0;
        req_ready   = 1'b0;
        res_valid   = 1'b0;
        advance     = 1'b0;
        res.item_value = val_reg;
        res.group      = ble_pkg::GROUP_SINGLE;
        res.status     = rep_st_reg;
        res.last       = 1'b1;
        res.length     = len_reg;

        case (state_reg)
            S_IDLE:
            begin
                req_ready = 1'b1;
                if (req_valid)
                begin
                    val_next    = '0;
                    rep_st_next = ble_pkg::STATUS_BAD;
                    state_next  = S_REPLY;
                    case (ble_pkg::kind_t'(kind))
                        ble_pkg::KIND_PUSH_FRONT, ble_pkg::KIND_PUSH_BACK:
                        begin
                            if (full)
                            begin
                                rep_st_next = ble_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                val_next = value;
                                dst_next = AW'(len_reg);
                                if (ble_pkg::kind_t'(kind) == ble_pkg::KIND_PUSH_BACK)
                                begin
                                    ins_next   = AW'(len_reg);
                                    state_next = S_WRITE;
                                end
                                else
                                begin
                                    ins_next   = '0;
                                    state_next = (len_reg != '0) ? S_SHIFT_RD : S_WRITE;
                                end
                            end
                        end
                        ble_pkg::KIND_INSERT:
                        begin
                            if (pos_bad)
                            begin
                                rep_st_next = ble_pkg::STATUS_BAD;
                            end
                            else if (full)
                            begin
                                rep_st_next = ble_pkg::STATUS_FULL;
                            end
                            else
                            begin
                                val_next   = value;
                                dst_next   = AW'(len_reg);
                                ins_next   = AW'(position);
                                state_next = (PW'(len_reg) > position) ? S_SHIFT_RD : S_WRITE;
                            end
                        end
                        ble_pkg::KIND_READ:
                        begin
                            if (!pos_bad)
                            begin
                                ram_re      = 1'b1;
                                ram_raddr   = AW'(position - PW'(1));
                                rep_st_next = ble_pkg::STATUS_OK;
                                state_next  = S_RD_WAIT;
                            end
                        end
                        ble_pkg::KIND_SPLIT_PAR, ble_pkg::KIND_SPLIT_AT:
                        begin
                            if (len_reg == '0)
                            begin
                                rep_st_next = ble_pkg::STATUS_EMPTY;
                            end
                            else
                            begin
                                parity_next = (ble_pkg::kind_t'(kind) == ble_pkg::KIND_SPLIT_PAR);
                                pos_next    = position;
                                idx_next    = '0;
                                cnt_next    = '0;
                                pass_next   = 1'b0;
                                state_next  = S_STRM_RD;
                            end
                        end
                        default:
                        begin
                            rep_st_next = ble_pkg::STATUS_BAD;
                        end
                    endcase
                end
            end
            S_SHIFT_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = dst_reg - AW'(1);
                state_next = S_SHIFT;
            end
            S_SHIFT:
            begin
                ram_we    = 1'b1;
                ram_waddr = dst_reg;
                ram_wdata = ram_rdata;
                if ((dst_reg - AW'(1)) > ins_reg)
                begin
                    ram_re    = 1'b1;
                    ram_raddr = dst_reg - AW'(2);
                    dst_next  = dst_reg - AW'(1);
                end
                else
                begin
                    state_next = S_WRITE;
                end
            end
            S_WRITE:
            begin
                ram_we      = 1'b1;
                ram_waddr   = ins_reg;
                ram_wdata   = val_reg;
                len_next    = len_reg + LW'(1);
                rep_st_next = ble_pkg::STATUS_OK;
                state_next  = S_REPLY;
            end
            S_RD_WAIT:
            begin
                val_next   = ram_rdata;
                state_next = S_REPLY;
            end
            S_REPLY:
            begin
                res_valid = 1'b1;
                if (res_ready)
                begin
                    state_next = S_IDLE;
                end
            end
            S_STRM_RD:
            begin
                ram_re     = 1'b1;
                ram_raddr  = idx_reg;
                state_next = S_STRM;
            end
            S_STRM:
            begin
                res.item_value = ram_rdata;
                res.status     = ble_pkg::STATUS_OK;
                res.last       = ((cnt_reg + LW'(1)) == len_reg);
                if (parity_reg)
                begin
                    res.group = pass_reg ? ble_pkg::GROUP_SECOND : ble_pkg::GROUP_FIRST;
                end
                else
                begin
                    res.group = ({{(PW-AW){1'b0}}, idx_reg} < pos_reg) ?
                                ble_pkg::GROUP_FIRST : ble_pkg::GROUP_SECOND;
                end
                if (want)
                begin
                    res_valid = 1'b1;
                    if (res_ready)
                    begin
                        advance  = 1'b1;
                        cnt_next = cnt_reg + LW'(1);
                    end
                end
                else
                begin
                    advance = 1'b1;
                end
                if (advance)
                begin
                    if (more)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = idx_reg + AW'(1);
                        idx_next  = idx_reg + AW'(1);
                    end
                    else if (parity_reg && !pass_reg)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = '0;
                        idx_next  = '0;
                        pass_next = 1'b1;
                    end
                    else
                    begin
                        state_next = S_IDLE;
                    end
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            len_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            len_reg   <= len_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dst_reg    <= dst_next;
        ins_reg    <= ins_next;
        idx_reg    <= idx_next;
        cnt_reg    <= cnt_next;
        pass_reg   <= pass_next;
        parity_reg <= parity_next;
        pos_reg    <= pos_next;
        val_reg    <= val_next;
        rep_st_reg <= rep_st_next;
    end

endmodule

>>> rtl/core/bounded_list_engine_core.sv
// Top level of the bounded list engine: sequencer plus output register.
// Depends on ble_pkg and ble_ctrl.
//
// A request on req_valid/req_ready names one list operation (kind, position,
// value). Results leave on rsp_valid/rsp_ready, one or more per request, the
// final one marked by last. Every result carries the list length after the
// operation.
// req_ready is high only while the sequencer is idle; one request is worked
// on at a time.
// Push front and insert move each later element up one place before the write,
// since the shift runs through the one RAM port pair. Splits visit every
// element, in two passes for the parity split.
// Results pass through a one-entry output register; a stall of the receiver
// holds the sequencer on the pending result until it is taken.
// Reset empties the list; element storage is not cleared and needs no pass.
module bounded_list_engine_core #(
    parameter int CAPACITY = 64
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                req_valid,
    output logic                req_ready,
    input  logic [2:0]          kind,
    input  logic [7:0]          position,
    input  logic signed [31:0]  value,
    output logic                rsp_valid,
    input  logic                rsp_ready,
    output logic signed [31:0]  item_value,
    output logic [1:0]          group,
    output logic [1:0]          status,
    output logic                last,
    output logic [6:0]          length
);

    ble_pkg::result_t res;
    ble_pkg::result_t out_reg;
    logic             res_valid;
    logic             res_ready;
    logic             out_valid_reg;

    ble_ctrl #(
        .CAPACITY(CAPACITY)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .kind      (kind),
        .position  (position),
        .value     (value),
        .res_valid (res_valid),
        .res_ready (res_ready),
        .res       (res)
    );

    assign res_ready = !out_valid_reg || rsp_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res_ready)
        begin
            out_valid_reg <= res_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res_ready && res_valid)
        begin
            out_reg <= res;
        end
    end

    assign rsp_valid  = out_valid_reg;
    assign item_value = out_reg.item_value;
    assign group      = out_reg.group;
    assign status     = out_reg.status;
    assign last       = out_reg.last;
    assign length     = out_reg.length;

endmodule

>>> test/bounded_list_engine_core_test.sv
// Self-checking testbench for bounded_list_engine_core: drives list requests and checks each
// result against a shadow copy of the list kept inside the bench.
// Depends on ble_pkg and the RTL of bounded_list_engine_core.
module bounded_list_engine_core_test;

    import ble_pkg::*;

    localparam int LIST_CAP     = 64;
    localparam int STALL_LIMIT  = 4000;
    localparam int DRAIN_CYCLES = 2 * LIST_CAP + 20;

    logic                    clk;
    logic                    rst_n;
    logic                    req_valid;
    logic                    req_ready;
    logic [KIND_W-1:0]       kind;
    logic [POS_W-1:0]        position;
    logic signed [VAL_W-1:0] value;
    logic                    rsp_valid;
    logic                    rsp_ready = 1'b0;
    logic signed [VAL_W-1:0] item_value;
    logic [GRP_W-1:0]        group;
    logic [ST_W-1:0]         status;
    logic                    last;
    logic [LEN_W-1:0]        length;

    logic signed [VAL_W-1:0] shadow_list [0:LIST_CAP-1];
    int                      shadow_len;
    result_t                 pending_results [$];
    result_t                 oldest_result;
    int                      error_count;
    int                      request_count;
    int                      result_count;
    int                      quiet_cycles;
    bit                      idle_on;

    bounded_list_engine_core #(
        .CAPACITY(LIST_CAP)
    ) i_dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .kind      (kind),
        .position  (position),
        .value     (value),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .item_value(item_value),
        .group     (group),
        .status    (status),
        .last      (last),
        .length    (length)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    function automatic void expect_reply(logic signed [VAL_W-1:0] v, logic [GRP_W-1:0] g,
                                         logic [ST_W-1:0] s, logic fin);
        result_t r;
        r.item_value = v;
        r.group      = g;
        r.status     = s;
        r.last       = fin;
        r.length     = LEN_W'(shadow_len);
        pending_results.push_back(r);
    endfunction

    function automatic void predict_list_op(logic [KIND_W-1:0] k, logic [POS_W-1:0] p,
                                            logic signed [VAL_W-1:0] v);
        int i;
        int n;
        n = 0;
        case (k)
            KIND_PUSH_FRONT, KIND_PUSH_BACK:
            begin
                if (shadow_len >= LIST_CAP)
                begin
                    expect_reply(0, GROUP_SINGLE, STATUS_FULL, 1'b1);
                end
                else
                begin
                    if (k == KIND_PUSH_FRONT)
                    begin
                        for (i = shadow_len; i > 0; i--)
                            shadow_list[i] = shadow_list[i-1];
                        shadow_list[0] = v;
                    end
                    else
                    begin
                        shadow_list[shadow_len] = v;
                    end
                    shadow_len++;
                    expect_reply(v, GROUP_SINGLE, STATUS_OK, 1'b1);
                end
            end
            KIND_INSERT:
            begin
                if (p == 0 || p > shadow_len)
                begin
                    expect_reply(0, GROUP_SINGLE, STATUS_BAD, 1'b1);
                end
                else if (shadow_len >= LIST_CAP)
                begin
                    expect_reply(0, GROUP_SINGLE, STATUS_FULL, 1'b1);
                end
                else
                begin
                    for (i = shadow_len; i > p; i--)
                        shadow_list[i] = shadow_list[i-1];
                    shadow_list[p] = v;
                    shadow_len++;
                    expect_reply(v, GROUP_SINGLE, STATUS_OK, 1'b1);
                end
            end
            KIND_READ:
            begin
                if (p == 0 || p > shadow_len)
                    expect_reply(0, GROUP_SINGLE, STATUS_BAD, 1'b1);
                else
                    expect_reply(shadow_list[p-1], GROUP_SINGLE, STATUS_OK, 1'b1);
            end
            KIND_SPLIT_PAR:
            begin
                if (shadow_len == 0)
                begin
                    expect_reply(0, GROUP_SINGLE, STATUS_EMPTY, 1'b1);
                end
                else
                begin
                    for (i = 0; i < shadow_len; i++)
                    begin
                        if (shadow_list[i][0] == 1'b0)
                        begin
                            expect_reply(shadow_list[i], GROUP_FIRST, STATUS_OK,
                                         n == shadow_len - 1);
                            n++;
                        end
                    end
                    for (i = 0; i < shadow_len; i++)
                    begin
                        if (shadow_list[i][0] == 1'b1)
                        begin
                            expect_reply(shadow_list[i], GROUP_SECOND, STATUS_OK,
                                         n == shadow_len - 1);
                            n++;
                        end
                    end
                end
            end
            KIND_SPLIT_AT:
            begin
                if (shadow_len == 0)
                begin
                    expect_reply(0, GROUP_SINGLE, STATUS_EMPTY, 1'b1);
                end
                else
                begin
                    for (i = 0; i < shadow_len; i++)
                        expect_reply(shadow_list[i], (i < p) ? GROUP_FIRST : GROUP_SECOND,
                                     STATUS_OK, i == shadow_len - 1);
                end
            end
            default:
            begin
                expect_reply(0, GROUP_SINGLE, STATUS_BAD, 1'b1);
            end
        endcase
    endfunction

    // Called and left at a falling edge; valid stays high until the next call, which may drop it first.
    task automatic send_request(logic [KIND_W-1:0] k, logic [POS_W-1:0] p,
                                logic signed [VAL_W-1:0] v);
        while (idle_on && $urandom_range(99) < 37)
        begin
            req_valid <= 1'b0;
            @(negedge clk);
        end
        req_valid <= 1'b1;
        kind      <= k;
        position  <= p;
        value     <= v;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
        predict_list_op(k, p, v);
        request_count++;
        @(negedge clk);
    endtask

    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(7))
            0: return 32'sh0000_0000;
            1: return -32'sd1;
            2: return 32'sh7FFF_FFFF;
            3: return 32'sh8000_0000;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [POS_W-1:0] pick_position(int len);
        case ($urandom_range(9))
            0: return 8'd0;
            1: return POS_W'(len + 1);
            2: return POS_W'($urandom_range(255));
            3: return POS_W'(len);
            default: return (len == 0) ? POS_W'($urandom_range(1, 2))
                                       : POS_W'($urandom_range(1, len));
        endcase
    endfunction

    task automatic test_empty_list();
        send_request(KIND_READ, 8'd1, 32'sd0);
        send_request(KIND_READ, 8'd0, 32'sd0);
        send_request(KIND_SPLIT_PAR, 8'd0, 32'sd0);
        send_request(KIND_SPLIT_AT, 8'd3, 32'sd0);
        send_request(KIND_INSERT, 8'd1, 32'sd7);
        send_request(3'd6, 8'd0, 32'sd0);
        send_request(3'd7, 8'hFF, -32'sd1);
    endtask

    task automatic test_list_edits();
        send_request(KIND_PUSH_BACK, 8'd0, 32'sh7FFF_FFFF);
        send_request(KIND_PUSH_FRONT, 8'hFF, 32'sh8000_0000);
        send_request(KIND_PUSH_BACK, 8'd0, -32'sd1);
        send_request(KIND_PUSH_BACK, 8'd0, 32'sd0);
        send_request(KIND_INSERT, 8'd1, 32'sd5);
        send_request(KIND_INSERT, 8'd5, 32'sh5555_5555);
        send_request(KIND_INSERT, 8'd7, 32'sd9);
        send_request(KIND_INSERT, 8'd0, 32'sd9);
    endtask

    task automatic test_list_queries();
        send_request(KIND_READ, 8'd1, 32'sd0);
        send_request(KIND_READ, 8'd6, 32'sd0);
        send_request(KIND_READ, 8'd7, 32'sd0);
        send_request(KIND_READ, 8'hFF, 32'sd0);
        send_request(KIND_SPLIT_PAR, 8'd0, 32'sd0);
        send_request(KIND_SPLIT_AT, 8'd0, 32'sd0);
        send_request(KIND_SPLIT_AT, 8'd3, 32'sd0);
        send_request(KIND_SPLIT_AT, 8'hFF, 32'sd0);
    endtask

    task automatic test_random_requests(int count);
        int                      sel;
        logic [KIND_W-1:0]       k;
        logic [POS_W-1:0]        p;
        repeat (count)
        begin
            sel = $urandom_range(99);
            p   = pick_position(shadow_len);
            if (sel < 12)
                k = ($urandom_range(1) == 0) ? KIND_PUSH_FRONT : KIND_PUSH_BACK;
            else if (sel < 27)
                k = KIND_INSERT;
            else if (sel < 55)
                k = KIND_READ;
            else if (sel < 72)
                k = KIND_SPLIT_PAR;
            else if (sel < 94)
                k = KIND_SPLIT_AT;
            else
                k = KIND_W'($urandom_range(6, 7));
            send_request(k, p, pick_value());
        end
    endtask

    task automatic test_full_list();
        while (shadow_len < LIST_CAP)
            send_request(KIND_PUSH_BACK, POS_W'($urandom_range(255)), pick_value());
        send_request(KIND_PUSH_FRONT, 8'd0, 32'sd1);
        send_request(KIND_PUSH_BACK, 8'd0, 32'sd2);
        send_request(KIND_INSERT, 8'd64, 32'sd3);
        send_request(KIND_INSERT, 8'd65, 32'sd4);
        send_request(KIND_READ, 8'd64, 32'sd0);
        send_request(KIND_SPLIT_PAR, 8'd0, 32'sd0);
        send_request(KIND_SPLIT_AT, 8'd32, 32'sd0);
    endtask

    always @(negedge clk)
    begin
        if (!rst_n)
            rsp_ready <= 1'b0;
        else
            rsp_ready <= !(idle_on && $urandom_range(99) < 37);
    end

    function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got)
        begin
            $display("%0t: %s mismatch: expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin
        if (rst_n && rsp_valid && rsp_ready)
        begin
            result_count++;
            if (pending_results.size() == 0)
            begin
                $display("%0t: unexpected result: expected none, actual value %0h group %0d",
                         $time, item_value, group);
                error_count++;
            end
            else
            begin
                oldest_result = pending_results.pop_front();
                check_field("item_value", oldest_result.item_value, item_value);
                check_field("group", 32'(oldest_result.group), 32'(group));
                check_field("status", 32'(oldest_result.status), 32'(status));
                check_field("last", 32'(oldest_result.last), 32'(last));
                check_field("length", 32'(oldest_result.length), 32'(length));
            end
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout after %0d cycles without a handshake.", quiet_cycles);
                $display("FAILED: results differ");
                $finish;
            end
        end
    end

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        kind          = '0;
        position      = '0;
        value         = '0;
        shadow_len    = 0;
        error_count   = 0;
        request_count = 0;
        result_count  = 0;
        quiet_cycles  = 0;
        idle_on       = 1'b1;
        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_list_edits();
        test_list_queries();
        test_random_requests(150);
        idle_on = 1'b0;
        test_random_requests(100);
        idle_on = 1'b1;
        test_random_requests(150);
        test_full_list();
        req_valid <= 1'b0;

        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        if (pending_results.size() != 0)
        begin
            $display("%0t: %0d results never arrived", $time, pending_results.size());
            error_count++;
        end

        $display("Sent %0d list requests and checked %0d results; final length %0d.",
                 request_count, result_count, shadow_len);
        $display("Covered pushes, inserts, reads and both splits on empty, partial and full lists.");
        if (error_count == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
